// ===== rtl/core/red_queue_admission_macros.svh =====
// assertion macros for the red queue admission block
`ifndef RED_QUEUE_ADMISSION_MACROS_SVH
`define RED_QUEUE_ADMISSION_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define RQA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rqa assertion failed");
// next-cycle implication, disabled in reset
`define RQA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rqa assertion failed");
`else
`define RQA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RQA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/rqa_pkg.sv =====
// shared types and constants for the red queue admission block
package rqa_pkg;

    localparam int TIME_BITS = 48;
    localparam int MUL_AW    = 48;
    localparam int MUL_BW    = 24;
    localparam int DIV_W     = 64;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [17:0] TWO_Q16 = 18'h20000;
    localparam logic [39:0] DT_CAP  = 40'h80_0000_0000;

    // register indexes
    localparam logic [2:0] CFG_BIT_RATE  = 3'd0;
    localparam logic [2:0] CFG_MIN_TH    = 3'd1;
    localparam logic [2:0] CFG_MAX_TH    = 3'd2;
    localparam logic [2:0] CFG_CAP_TH    = 3'd3;
    localparam logic [2:0] CFG_MAX_PROB  = 3'd4;
    localparam logic [2:0] CFG_WEIGHT    = 3'd5;
    localparam logic [2:0] CFG_MEAN      = 3'd6;
    localparam logic [2:0] CFG_WAIT      = 3'd7;

    // register defaults
    localparam logic [23:0] RST_BIT_RATE = 24'd65536;
    localparam logic [16:0] RST_MIN_TH   = 17'd3277;
    localparam logic [16:0] RST_MAX_TH   = 17'd32768;
    localparam logic [16:0] RST_CAP_TH   = 17'd65536;
    localparam logic [16:0] RST_MAX_PROB = 17'd6554;
    localparam logic [15:0] RST_WEIGHT   = 16'd131;
    localparam logic [15:0] RST_MEAN     = 16'd500;

    typedef enum logic [1:0] {
        OC_DROP_RED = 2'd0,
        OC_DROP_EXT = 2'd1,
        OC_ENQ      = 2'd2,
        OC_ENQ_MARK = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [15:0]          packet_bytes;
        logic [TIME_BITS-1:0] arrival_time;
        logic [15:0]          red_random;
        logic [15:0]          extra_random;
        logic [16:0]          extra_drop_prob;
        logic                 no_drop;
    } t_in_item;

    typedef struct packed {
        t_outcome             outcome;
        logic [19:0]          queue_level;
        logic [19:0]          average_level;
        logic [16:0]          loss_now;
        logic [TIME_BITS-1:0] drain_time;
    } t_out_item;

    // sequencer steps
    typedef enum logic [4:0] {
        ST_PREP, ST_DRAIN, ST_IDLEB, ST_IDLEM, ST_POWI, ST_POWR, ST_POWB,
        ST_AVGM, ST_AVGW, ST_LOSS, ST_L1M, ST_L1D, ST_L2M, ST_L2D,
        ST_CNT, ST_PM, ST_CORR, ST_CDIV, ST_SCHK, ST_SMUL, ST_SDIV,
        ST_DEC, ST_EDIV, ST_DONE
    } t_step;

    typedef enum logic [1:0] {
        LB_SET,
        LB_LIN1,
        LB_LIN2
    } t_lbr;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ISSUE,
        CS_WAIT
    } t_cstate;

    typedef struct packed {
        t_step step;
        logic  load;
        logic  start_mul;
        logic  start_div;
        logic  capture;
        logic  out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic exp_cur_zero;
        logic exp_cur_bit;
        logic exp_next_zero;
        logic exp_next_bit;
        t_lbr lbr;
        logic corr_div;
        logic loss_lt_one;
        logic enq;
    } t_dp_status;

endpackage

// ===== rtl/core/rqa_mul.sv =====
// multiplier built from two 24x24 partial products
module rqa_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rqa_pkg::MUL_AW-1:0] i_a,
    input  logic [rqa_pkg::MUL_BW-1:0] i_b,
    output logic                      o_done,
    output logic [63:0]               o_prod
);
    import rqa_pkg::*;

    logic        r_ph;
    logic        r_done;
    logic [47:0] r_lo;
    logic [23:0] r_ahi;
    logic [23:0] r_b;
    logic [63:0] r_prod;
    logic [47:0] w_hi;
    logic [63:0] n_prod;

    // upper partial product and sum
    assign w_hi   = r_ahi * r_b;
    assign n_prod = 64'(r_lo) + {w_hi[39:0], 24'h0};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ph   <= i_start;
            r_done <= r_ph;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo  <= i_a[23:0] * i_b;
            r_ahi <= i_a[47:24];
            r_b   <= i_b;
        end
        if (r_ph) begin
            r_prod <= n_prod;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule

// ===== rtl/core/rqa_div.sv =====
// restoring divider, one quotient bit per cycle
module rqa_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rqa_pkg::DIV_W-1:0] i_num,
    input  logic [rqa_pkg::DIV_W-1:0] i_den,
    output logic                      o_done,
    output logic [rqa_pkg::DIV_W-1:0] o_quo
);
    import rqa_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [5:0]       r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W:0]   w_sh;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    // trial subtract
    assign w_sh   = {r_rem, r_quo[DIV_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_sh[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== rtl/core/rqa_ctrl.sv =====
// sequencer that steps the datapath through one packet
module rqa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    input  rqa_pkg::t_dp_status i_status,
    output rqa_pkg::t_dp_cmd    o_cmd
);
    import rqa_pkg::*;

    typedef enum logic [1:0] {
        K_ALU,
        K_MUL,
        K_DIV
    } t_kind;

    t_cstate r_state, n_state;
    t_step   r_step, n_step;
    logic    r_out_valid, n_out_valid;
    t_step   w_next;
    t_kind   w_kind;

    function automatic t_kind step_kind(input t_step s);
        t_kind k;
        case (s)
            ST_DRAIN, ST_IDLEB, ST_POWR, ST_POWB, ST_AVGM, ST_AVGW,
            ST_L1M, ST_L2M, ST_PM, ST_SMUL: k = K_MUL;
            ST_IDLEM, ST_L1D, ST_L2D, ST_CNT, ST_CDIV, ST_SDIV, ST_EDIV: k = K_DIV;
            default: k = K_ALU;
        endcase
        return k;
    endfunction

    function automatic t_step step_next(input t_step s, input t_dp_status st);
        t_step n;
        case (s)
            ST_PREP:  n = ST_DRAIN;
            ST_DRAIN: n = ST_IDLEB;
            ST_IDLEB: n = ST_IDLEM;
            ST_IDLEM: n = ST_POWI;
            ST_POWI:  n = st.exp_cur_zero ? ST_AVGM : (st.exp_cur_bit ? ST_POWR : ST_POWB);
            ST_POWR:  n = st.exp_next_zero ? ST_AVGM : ST_POWB;
            ST_POWB:  n = st.exp_next_zero ? ST_AVGM : (st.exp_next_bit ? ST_POWR : ST_POWB);
            ST_AVGM:  n = ST_AVGW;
            ST_AVGW:  n = ST_LOSS;
            ST_LOSS: begin
                case (st.lbr)
                    LB_LIN1: n = ST_L1M;
                    LB_LIN2: n = ST_L2M;
                    default: n = ST_CNT;
                endcase
            end
            ST_L1M:   n = ST_L1D;
            ST_L1D:   n = ST_CNT;
            ST_L2M:   n = ST_L2D;
            ST_L2D:   n = ST_CNT;
            ST_CNT:   n = ST_PM;
            ST_PM:    n = ST_CORR;
            ST_CORR:  n = st.corr_div ? ST_CDIV : ST_SCHK;
            ST_CDIV:  n = ST_SCHK;
            ST_SCHK:  n = st.loss_lt_one ? ST_SMUL : ST_DEC;
            ST_SMUL:  n = ST_SDIV;
            ST_SDIV:  n = ST_DEC;
            ST_DEC:   n = st.enq ? ST_EDIV : ST_DONE;
            ST_EDIV:  n = ST_DONE;
            default:  n = ST_DONE;
        endcase
        return n;
    endfunction

    assign w_kind = step_kind(r_step);
    assign w_next = step_next(r_step, i_status);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_IDLE;
            r_step      <= ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        n_out_valid     = r_out_valid && i_out_stall;
        o_cmd           = '0;
        o_cmd.step      = r_step;
        o_in_stall      = 1'b1;
        case (r_state)
            CS_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = ST_PREP;
                    n_state    = CS_ISSUE;
                end
            end
            CS_ISSUE: begin
                if (r_step == ST_DONE) begin
                    if (!r_out_valid || !i_out_stall) begin
                        o_cmd.out_load = 1'b1;
                        n_out_valid    = 1'b1;
                        n_state        = CS_IDLE;
                    end
                end else begin
                    case (w_kind)
                        K_MUL: begin
                            o_cmd.start_mul = 1'b1;
                            n_state         = CS_WAIT;
                        end
                        K_DIV: begin
                            o_cmd.start_div = 1'b1;
                            n_state         = CS_WAIT;
                        end
                        default: begin
                            o_cmd.capture = 1'b1;
                            n_step        = w_next;
                        end
                    endcase
                end
            end
            CS_WAIT: begin
                if ((w_kind == K_MUL && i_status.mul_done) ||
                    (w_kind == K_DIV && i_status.div_done)) begin
                    o_cmd.capture = 1'b1;
                    n_step        = w_next;
                    n_state       = CS_ISSUE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== rtl/core/rqa_dp.sv =====
// datapath: queue state, config registers, shared multiplier and divider
module rqa_dp #(
    parameter int BUFFER_BYTES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rqa_pkg::t_dp_cmd    i_cmd,
    output rqa_pkg::t_dp_status o_status,
    input  rqa_pkg::t_in_item   i_in_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data,
    output rqa_pkg::t_out_item  o_out_data
);
    import rqa_pkg::*;

    localparam int BUF_BITS = 8 * BUFFER_BYTES;
    localparam int QW = $clog2(BUF_BITS + 8 * 65535 + 1);
    localparam int AW = QW + 16;
    localparam int TW = QW + 1;
    localparam int CW = TW + 16;
    localparam logic [TW-1:0] BUF_T    = TW'(BUF_BITS);
    localparam logic [TW-1:0] QMIN_DEF = TW'(BUF_BITS / 20);
    localparam logic [TW-1:0] QMAX_DEF = TW'(4 * BUFFER_BYTES);

    // config registers
    logic [23:0] r_rate;
    logic [16:0] r_min, r_max, r_cap, r_pmax;
    logic [15:0] r_w, r_mean;
    logic        r_wait;

    // packet state
    logic [QW-1:0]        r_queue;
    logic [AW-1:0]        r_avg;
    logic [16:0]          r_loss;
    logic                 r_crossed;
    logic [31:0]          r_bsd;
    logic [TIME_BITS-1:0] r_last;
    logic [TIME_BITS-1:0] r_empty;

    // per-packet temporaries
    t_in_item    r_in;
    logic [39:0] r_ta, r_tb;
    logic [63:0] r_tmp;
    logic [31:0] r_exp;
    logic [16:0] r_base, r_pw;
    logic [5:0]  r_i;
    logic [28:0] r_cnt;
    logic [45:0] r_p;
    t_outcome    r_outcome;
    t_out_item   r_out;

    // unit ports
    logic [MUL_AW-1:0] w_ma;
    logic [MUL_BW-1:0] w_mb;
    logic              w_mdone;
    logic [63:0]       w_mprod;
    logic [DIV_W-1:0]  w_dn, w_dd, w_dq;
    logic              w_ddone;

    // helpers
    logic [23:0]          w_rate;
    logic [15:0]          w_mean;
    logic [18:0]          w_mean_bits;
    logic [16:0]          w_pmax;
    logic [TW-1:0]        w_qmin, w_qmax, w_qcap;
    logic [TW:0]          w_qmax2;
    logic [CW-1:0]        w_avg_c, w_qmin_s, w_qmax_s, w_qcap_s;
    logic [18:0]          w_len;
    logic [TIME_BITS-1:0] w_now, w_dt, w_idle;
    logic [39:0]          w_dt_c, w_idle_c;
    logic [32:0]          w_bsd_sum;
    logic [31:0]          w_bsd_sat;
    logic [47:0]          w_d, w_q48, w_qd;
    logic                 w_below, w_lt_max, w_lt_cap;
    logic                 w_red, w_xdrop, w_enq;
    logic [QW:0]          w_qlen;

    // effective config values and thresholds in bits
    assign w_rate      = (r_rate == '0) ? 24'd1 : r_rate;
    assign w_mean      = (r_mean == '0) ? 16'd1 : r_mean;
    assign w_mean_bits = {w_mean, 3'b0};
    assign w_pmax      = (r_pmax > ONE_Q16) ? ONE_Q16 : r_pmax;
    assign w_qmin      = (r_min != '0) ? TW'({r_min, 3'b0}) : QMIN_DEF;
    assign w_qmax      = (r_max != '0) ? TW'({r_max, 3'b0}) : QMAX_DEF;
    assign w_qmax2     = {w_qmax, 1'b0};
    assign w_qcap      = (r_cap != '0) ? TW'({r_cap, 3'b0}) :
                         (({1'b0, BUF_T} < w_qmax2) ? BUF_T : w_qmax2[TW-1:0]);
    assign w_avg_c     = CW'(r_avg);
    assign w_qmin_s    = {w_qmin, 16'h0};
    assign w_qmax_s    = {w_qmax, 16'h0};
    assign w_qcap_s    = {w_qcap, 16'h0};

    // elapsed time and idle gap, capped
    assign w_len     = {r_in.packet_bytes, 3'b0};
    assign w_now     = r_in.arrival_time;
    assign w_dt      = (w_now > r_last) ? w_now - r_last : '0;
    assign w_idle    = (w_now > r_empty) ? w_now - r_empty : '0;
    assign w_dt_c    = (w_dt > TIME_BITS'(DT_CAP)) ? DT_CAP : w_dt[39:0];
    assign w_idle_c  = (w_idle > TIME_BITS'(DT_CAP)) ? DT_CAP : w_idle[39:0];
    assign w_bsd_sum = {1'b0, r_bsd} + 33'(w_len);
    assign w_bsd_sat = w_bsd_sum[32] ? 32'hFFFF_FFFF : w_bsd_sum[31:0];

    // drain result
    assign w_d   = w_mprod[63:16];
    assign w_q48 = 48'(r_queue);
    assign w_qd  = (w_q48 > w_d) ? w_q48 - w_d : '0;

    // loss branch
    assign w_below  = (r_queue == '0) || (w_avg_c < w_qmin_s);
    assign w_lt_max = w_avg_c < w_qmax_s;
    assign w_lt_cap = w_avg_c < w_qcap_s;

    // drop decision
    assign w_qlen  = {1'b0, r_queue} + (QW+1)'(w_len);
    assign w_red   = (w_qlen > (QW+1)'(BUF_BITS)) || (r_loss == ONE_Q16) ||
                     ((r_loss != '0) && (17'(r_in.red_random) < r_loss));
    assign w_xdrop = 17'(r_in.extra_random) < r_in.extra_drop_prob;
    assign w_enq   = r_in.no_drop || (!w_red && !w_xdrop);

    // status to the sequencer
    always_comb begin
        o_status               = '0;
        o_status.mul_done      = w_mdone;
        o_status.div_done      = w_ddone;
        o_status.exp_cur_zero  = (r_exp >> r_i) == '0;
        o_status.exp_cur_bit   = r_exp[r_i[4:0]];
        o_status.exp_next_zero = (r_exp >> (r_i + 6'd1)) == '0;
        o_status.exp_next_bit  = r_exp[r_i[4:0] + 5'd1];
        if (w_below || !r_crossed || (!w_lt_max && !w_lt_cap)) begin
            o_status.lbr = LB_SET;
        end else if (w_lt_max) begin
            o_status.lbr = LB_LIN1;
        end else begin
            o_status.lbr = LB_LIN2;
        end
        o_status.corr_div    = r_wait ? (r_p >= 46'(ONE_Q16) && r_p < 46'(TWO_Q16))
                                      : (r_p < 46'(ONE_Q16));
        o_status.loss_lt_one = r_loss < ONE_Q16;
        o_status.enq         = w_enq;
    end

    // operand selection for the shared units
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_dn = '0;
        w_dd = '0;
        case (i_cmd.step)
            ST_DRAIN: begin w_ma = 48'(r_ta);     w_mb = w_rate; end
            ST_IDLEB: begin w_ma = 48'(r_tb);     w_mb = w_rate; end
            ST_POWR:  begin w_ma = 48'(r_pw);     w_mb = 24'(r_base); end
            ST_POWB:  begin w_ma = 48'(r_base);   w_mb = 24'(r_base); end
            ST_AVGM:  begin w_ma = 48'(r_avg);    w_mb = 24'(r_pw); end
            ST_AVGW:  begin w_ma = 48'(r_queue);  w_mb = 24'(r_w); end
            ST_L1M:   begin w_ma = 48'(w_avg_c - w_qmin_s); w_mb = 24'(w_pmax); end
            ST_L2M:   begin w_ma = 48'(w_avg_c - w_qmax_s); w_mb = 24'(ONE_Q16 - w_pmax); end
            ST_PM:    begin w_ma = 48'(r_cnt);    w_mb = 24'(r_loss); end
            ST_SMUL:  begin w_ma = 48'(r_loss);   w_mb = 24'(r_in.packet_bytes); end
            ST_IDLEM: begin w_dn = r_tmp;         w_dd = 64'(w_mean_bits); end
            ST_L1D:   begin w_dn = r_tmp;         w_dd = 64'({w_qmax - w_qmin, 16'h0}); end
            ST_L2D:   begin w_dn = r_tmp;         w_dd = 64'({w_qcap - w_qmax, 16'h0}); end
            ST_CNT:   begin w_dn = 64'(r_bsd);    w_dd = 64'(w_mean_bits); end
            ST_CDIV: begin
                w_dn = 64'({r_loss, 16'h0});
                w_dd = r_wait ? 64'(TWO_Q16) - 64'(r_p) : 64'(ONE_Q16) - 64'(r_p);
            end
            ST_SDIV:  begin w_dn = r_tmp;         w_dd = 64'(w_mean); end
            ST_EDIV:  begin w_dn = 64'({r_queue, 16'h0}); w_dd = 64'(w_rate); end
            default: ;
        endcase
    end

    rqa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_mul),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_mprod)
    );

    rqa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_div),
        .i_num   (w_dn),
        .i_den   (w_dd),
        .o_done  (w_ddone),
        .o_quo   (w_dq)
    );

    // config and queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= RST_BIT_RATE;
            r_min     <= RST_MIN_TH;
            r_max     <= RST_MAX_TH;
            r_cap     <= RST_CAP_TH;
            r_pmax    <= RST_MAX_PROB;
            r_w       <= RST_WEIGHT;
            r_mean    <= RST_MEAN;
            r_wait    <= 1'b1;
            r_queue   <= '0;
            r_avg     <= '0;
            r_loss    <= '0;
            r_crossed <= 1'b0;
            r_bsd     <= '0;
            r_last    <= '0;
            r_empty   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BIT_RATE: r_rate <= i_cfg_data;
                    CFG_MIN_TH:   r_min  <= i_cfg_data[16:0];
                    CFG_MAX_TH:   r_max  <= i_cfg_data[16:0];
                    CFG_CAP_TH:   r_cap  <= i_cfg_data[16:0];
                    CFG_MAX_PROB: r_pmax <= i_cfg_data[16:0];
                    CFG_WEIGHT:   r_w    <= i_cfg_data[15:0];
                    CFG_MEAN:     r_mean <= i_cfg_data[15:0];
                    CFG_WAIT:     r_wait <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                case (i_cmd.step)
                    ST_PREP: begin
                        r_bsd  <= w_bsd_sat;
                        r_last <= w_now;
                    end
                    ST_DRAIN: begin
                        r_queue <= (w_qd > 48'(BUF_BITS)) ? QW'(BUF_BITS) : QW'(w_qd);
                    end
                    ST_AVGM: r_avg <= w_mprod[AW+15:16];
                    ST_AVGW: r_avg <= r_avg + w_mprod[AW-1:0];
                    ST_LOSS: begin
                        if (w_below) begin
                            r_crossed <= 1'b0;
                            r_loss    <= '0;
                        end else if (!r_crossed) begin
                            r_crossed <= 1'b1;
                            r_loss    <= '0;
                            r_bsd     <= '0;
                        end else if (!w_lt_max && !w_lt_cap) begin
                            r_loss <= ONE_Q16;
                        end
                    end
                    ST_L1D: r_loss <= w_dq[16:0];
                    ST_L2D: r_loss <= w_pmax + w_dq[16:0];
                    ST_CORR: begin
                        if (r_wait) begin
                            if (r_p < 46'(ONE_Q16)) begin
                                r_loss <= '0;
                            end else if (r_p >= 46'(TWO_Q16)) begin
                                r_loss <= ONE_Q16;
                            end
                        end else if (r_p >= 46'(ONE_Q16)) begin
                            r_loss <= ONE_Q16;
                        end
                    end
                    ST_CDIV, ST_SDIV: begin
                        r_loss <= (w_dq > 64'(ONE_Q16)) ? ONE_Q16 : w_dq[16:0];
                    end
                    ST_DEC: begin
                        if (w_enq) begin
                            r_queue <= w_qlen[QW-1:0];
                        end else if (w_red) begin
                            r_bsd <= '0;
                        end
                    end
                    ST_EDIV: r_empty <= w_now + w_dq[TIME_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // per-packet temporaries and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.capture) begin
            case (i_cmd.step)
                ST_PREP: begin
                    r_ta <= w_dt_c;
                    r_tb <= w_idle_c;
                end
                ST_IDLEB: r_tmp <= 64'(w_mprod[63:16]);
                ST_IDLEM: begin
                    r_exp  <= w_dq[31:0] + 32'd1;
                    r_base <= ONE_Q16 - 17'(r_w);
                    r_pw   <= ONE_Q16;
                    r_i    <= '0;
                end
                ST_POWR: r_pw <= w_mprod[32:16];
                ST_POWB: begin
                    r_base <= w_mprod[32:16];
                    r_i    <= r_i + 6'd1;
                end
                ST_L1M, ST_L2M, ST_SMUL: r_tmp <= w_mprod;
                ST_CNT: r_cnt <= w_dq[28:0];
                ST_PM:  r_p   <= w_mprod[45:0];
                ST_DEC: begin
                    if (!r_in.no_drop && w_red) begin
                        r_outcome <= OC_DROP_RED;
                    end else if (!r_in.no_drop && w_xdrop) begin
                        r_outcome <= OC_DROP_EXT;
                    end else if (w_red || w_xdrop) begin
                        r_outcome <= OC_ENQ_MARK;
                    end else begin
                        r_outcome <= OC_ENQ;
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out.outcome       <= r_outcome;
            r_out.queue_level   <= r_queue[19:0];
            r_out.average_level <= r_avg[35:16];
            r_out.loss_now      <= r_loss;
            r_out.drain_time    <= r_empty;
        end
    end

    assign o_out_data = r_out;
endmodule

// ===== rtl/core/red_queue_admission.sv =====
// red queue admission top: one packet per request
// each division gives one quotient bit per cycle, two to six divisions per packet
// the idle-decay power takes up to 63 multiplies on the shared multiplier
// next request taken only the cycle after the result loads, and that load waits out stalls
// synchronous active-low reset loads register defaults and clears all queue state
`include "red_queue_admission_macros.svh"

module red_queue_admission #(
    parameter int BUFFER_BYTES = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rqa_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rqa_pkg::t_out_item o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [23:0]       i_cfg_data
);
    import rqa_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    rqa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath
    rqa_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

    // checks
    `RQA_ASSERT_IMP(a_out_rise_from_load, i_clk, i_rst_n, $rose(o_out_valid), $past(w_cmd.out_load))
    `RQA_ASSERT_IMP(a_one_unit_at_a_time, i_clk, i_rst_n, w_cmd.start_mul, !w_cmd.start_div)
    `RQA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
endmodule
